FILE: design/usem_pkg.sv
package usem_pkg;

  localparam int unsigned LEN_OUT_W = 16;
  localparam int unsigned MAX_COUNTER_W = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] LEAD_C2 = 8'hC2;
  localparam logic [7:0] LEAD_E1 = 8'hE1;
  localparam logic [7:0] LEAD_E2 = 8'hE2;
  localparam logic [7:0] LEAD_E3 = 8'hE3;
  localparam logic [7:0] CONT_80 = 8'h80;
  localparam logic [7:0] CONT_81 = 8'h81;
  localparam logic [7:0] CONT_8A = 8'h8A;
  localparam logic [7:0] CONT_9A = 8'h9A;
  localparam logic [7:0] CONT_9F = 8'h9F;
  localparam logic [7:0] CONT_A0 = 8'hA0;
  localparam logic [7:0] CONT_AF = 8'hAF;

  localparam logic [1:0] SEQ_NONE = 2'd0;

  localparam int unsigned LEAD_WINDOW = 3;

  typedef logic [1:0] seq_width_t;

  function automatic seq_width_t space_width(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    seq_width_t w;
    w = SEQ_NONE;
    if (c == CH_SPACE || c == CH_TAB) begin
      w = 2'd1;
    end else if (b == LEAD_C2 && c == CONT_A0) begin
      w = 2'd2;
    end else if (a == LEAD_E1 && b == CONT_9A && c == CONT_80) begin
      w = 2'd3;
    end else if (a == LEAD_E3 && b == CONT_80 && c == CONT_80) begin
      w = 2'd3;
    end else if (a == LEAD_E2 && b == CONT_81 && c == CONT_9F) begin
      w = 2'd3;
    end else if (a == LEAD_E2 && b == CONT_80 &&
                 (c == CONT_AF || (c >= CONT_80 && c <= CONT_8A))) begin
      w = 2'd3;
    end
    return w;
  endfunction

endpackage

FILE: design/unicode_space_edge_measure_top.sv
// channel | beat                     | tdata (low bit up)               | tlast     | tuser
// in_     | one byte of the run      | byte_value[7:0]                  | last_byte | -
// out_    | one result per run       | leading[15:0] trailing[31:16]    | -         | all_space[0]
//         |                          | core[47:32]                      |           | too_long[1]
// One byte per cycle while in_tready is high.
// Stages: input register, byte match and counter update, length arithmetic into out register.
// The out register loads whenever it is empty or being taken; the front two stages hold
// only while a result waits in both the middle stage and the out register.
// Reset (rst_n low, synchronous) empties the pipeline and clears the run counters.
module unicode_space_edge_measure_top #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_value[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // leading_length, trailing_length, core_length
  output logic [1:0]  out_tuser   // all_space, too_long
);

  localparam int unsigned CW = (LENGTH_BITS > usem_pkg::MAX_COUNTER_W) ?
                               usem_pkg::MAX_COUNTER_W : LENGTH_BITS;
  localparam logic [CW-1:0] LIMIT = {CW{1'b1}};

  logic adv;
  logic out_free;

  logic          a_valid_r;
  logic [7:0]    a_byte_r;
  logic          a_last_r;

  logic [15:0]   recent_r, recent_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          ovf_r, ovf_nxt;
  logic          lead_act_r, lead_act_nxt;
  logic [CW-1:0] lead_r, lead_nxt;
  logic [CW-1:0] hist_r [0:2];
  logic [CW-1:0] hist_nxt [0:2];

  logic          b_valid_r;
  logic [CW-1:0] b_n_r, b_lead_r, b_chain_r;
  logic          b_ovf_r;

  logic                  out_valid_r;
  logic [CW-1:0]         out_lead_r, out_trail_r, out_core_r;
  logic                  out_all_r, out_long_r;

  usem_pkg::seq_width_t w;
  logic [CW-1:0] pos_inc;
  logic [CW:0]   chain_sum;
  logic [CW-1:0] chain;
  logic          lead_hit;
  logic [CW:0]   lead_gap;

  logic          f_all;
  logic [CW-1:0] f_diff, f_trail;

  assign out_free = !out_valid_r || out_tready;
  assign adv = out_free || !b_valid_r;
  assign in_tready = adv;

  always_comb begin
    w = usem_pkg::space_width(recent_r[15:8], recent_r[7:0], a_byte_r);
    pos_inc = pos_r + CW'(1);
    chain_sum = {1'b0, hist_r[w - 2'd1]} + (CW + 1)'(w);
    chain = (w == usem_pkg::SEQ_NONE) ? '0 : chain_sum[CW-1:0];
    lead_hit = (w != usem_pkg::SEQ_NONE) &&
               ((CW + 2)'(lead_r) + (CW + 2)'(w) == (CW + 2)'(pos_inc));
    lead_gap = (CW + 1)'(pos_inc) - (CW + 1)'(lead_r);

    recent_nxt = recent_r;
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    lead_act_nxt = lead_act_r;
    lead_nxt = lead_r;
    hist_nxt[0] = hist_r[0];
    hist_nxt[1] = hist_r[1];
    hist_nxt[2] = hist_r[2];

    if (pos_r == LIMIT) begin
      ovf_nxt = 1'b1;
    end else begin
      hist_nxt[2] = hist_r[1];
      hist_nxt[1] = hist_r[0];
      hist_nxt[0] = chain;
      if (lead_act_r) begin
        if (lead_hit) begin
          lead_nxt = pos_inc;
        end else if (lead_gap >= (CW + 1)'(usem_pkg::LEAD_WINDOW)) begin
          lead_act_nxt = 1'b0;
        end
      end
      recent_nxt = {recent_r[7:0], a_byte_r};
      pos_nxt = pos_inc;
    end
  end

  always_comb begin
    f_all = (b_lead_r >= b_n_r);
    f_diff = b_n_r - b_lead_r;
    f_trail = (b_chain_r > f_diff) ? f_diff : b_chain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      recent_r <= '0;
      pos_r <= '0;
      ovf_r <= 1'b0;
      lead_act_r <= 1'b1;
      lead_r <= '0;
      hist_r[0] <= '0;
      hist_r[1] <= '0;
      hist_r[2] <= '0;
    end else begin
      if (adv) begin
        a_valid_r <= in_tvalid;
        b_valid_r <= a_valid_r && a_last_r;
        if (a_valid_r) begin
          if (a_last_r) begin
            recent_r <= '0;
            pos_r <= '0;
            ovf_r <= 1'b0;
            lead_act_r <= 1'b1;
            lead_r <= '0;
            hist_r[0] <= '0;
            hist_r[1] <= '0;
            hist_r[2] <= '0;
          end else begin
            recent_r <= recent_nxt;
            pos_r <= pos_nxt;
            ovf_r <= ovf_nxt;
            lead_act_r <= lead_act_nxt;
            lead_r <= lead_nxt;
            hist_r[0] <= hist_nxt[0];
            hist_r[1] <= hist_nxt[1];
            hist_r[2] <= hist_nxt[2];
          end
        end
      end
      if (out_free) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_byte_r <= in_tdata;
      a_last_r <= in_tlast;
      b_n_r <= pos_nxt;
      b_lead_r <= lead_nxt;
      b_chain_r <= hist_nxt[0];
      b_ovf_r <= ovf_nxt;
    end
    if (out_free) begin
      out_lead_r <= b_lead_r;
      out_trail_r <= f_all ? '0 : f_trail;
      out_core_r <= f_all ? '0 : f_diff - f_trail;
      out_all_r <= f_all;
      out_long_r <= b_ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {usem_pkg::LEN_OUT_W'(out_core_r), usem_pkg::LEN_OUT_W'(out_trail_r),
                      usem_pkg::LEN_OUT_W'(out_lead_r)};
  assign out_tuser = {out_long_r, out_all_r};

`ifndef SYNTHESIS
  a_lead_within_run: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r <= pos_r)
    else $error("leading count beyond byte position");

  a_lead_stop_gap: assert property (@(posedge clk) disable iff (!rst_n)
    !lead_act_r |-> ((CW + 2)'(pos_r) >= (CW + 2)'(lead_r) + (CW + 2)'(usem_pkg::LEAD_WINDOW)))
    else $error("leading parse stopped too early");

  a_all_space_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_all_r |-> (out_trail_r == '0 && out_core_r == '0))
    else $error("all-space result with nonzero trailing or core");

  a_overflow_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_long_r |->
      ((CW + 2)'(out_lead_r) + (CW + 2)'(out_trail_r) + (CW + 2)'(out_core_r) ==
       (CW + 2)'(LIMIT)))
    else $error("saturated run lengths do not add to the limit");
`endif

endmodule
